// ----- hw/rtl/tubs_pkg.sv -----
// shared types, constants and helpers for the touch unlock backlight slider
// no dependencies; imported by every rtl file of the block
package tubs_pkg;

    localparam int TICK_COUNT_BITS_DEF = 16;

    localparam int LEVEL_W   = 7;
    localparam int STRENGTH_W = 16;
    localparam int POS_W     = 16;
    localparam int HELD_W    = 11;
    localparam int VIB_W     = 8;
    localparam int HIDE_W    = 10;
    localparam int LONG_W    = 10;
    localparam int UNLOCK_W  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int AGE_CMP_W = 33;
    localparam int MAP_PROD_W = 23;

    localparam logic [LEVEL_W-1:0] LEVEL_MIN   = 7'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 7'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd80;
    localparam logic [MAP_PROD_W-1:0] LEVEL_SCALE = 23'd100;
    localparam logic signed [POS_W:0] POS_TOP = 17'sd16384;

    localparam logic [STRENGTH_W-1:0] THRESHOLD_RESET = 16'd100;
    localparam logic [LONG_W-1:0]     LONG_PRESS_RESET = 10'd50;
    localparam logic [UNLOCK_W-1:0]   UNLOCK_RESET = 16'd500;
    localparam logic [VIB_W-1:0]      VIB_GAP_RESET = 8'd10;
    localparam logic [HIDE_W-1:0]     HIDE_RESET = 10'd100;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BAR_ENABLED     = 3'd0,
        REG_INITIAL_LEVEL   = 3'd1,
        REG_TOUCH_THRESHOLD = 3'd2,
        REG_LONG_PRESS      = 3'd3,
        REG_UNLOCK_TICKS    = 3'd4,
        REG_VIBRATE_GAP     = 3'd5,
        REG_HIDE_TICKS      = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic                  bar_enabled;
        logic [LEVEL_W-1:0]    initial_level;
        logic [STRENGTH_W-1:0] touch_threshold;
        logic [LONG_W-1:0]     long_press_ticks;
        logic [UNLOCK_W-1:0]   unlock_ticks;
        logic [VIB_W-1:0]      vibrate_gap_ticks;
        logic [HIDE_W-1:0]     hide_ticks;
    } cfg_t;

    typedef struct packed {
        logic               load;
        logic [LEVEL_W-1:0] value;
    } level_load_t;

    typedef struct packed {
        logic [STRENGTH_W-1:0] upper_middle_strength;
        logic [STRENGTH_W-1:0] lower_middle_strength;
        logic                  slider_touched;
        logic [POS_W-1:0]      slider_position;
        logic                  menu_active;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               level_applied;
        logic               vibrate;
        logic               persist;
        logic               bar_visible;
        logic               suppress_detectors;
        logic               unlocked;
    } out_item_t;

    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W:0] v);
        logic [LEVEL_W-1:0] r;
        if (v < {1'b0, LEVEL_MIN}) begin
            r = LEVEL_MIN;
        end
        else if (v > {1'b0, LEVEL_MAX}) begin
            r = LEVEL_MAX;
        end
        else begin
            r = v[LEVEL_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/tubs_cfg_regs.sv -----
// configuration register file with write port and level load request
// depends on tubs_pkg
module tubs_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [tubs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tubs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output tubs_pkg::cfg_t                    cfg,
    output tubs_pkg::level_load_t             level_load
);
    import tubs_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.bar_enabled       <= 1'b1;
            cfg_reg.initial_level     <= LEVEL_RESET;
            cfg_reg.touch_threshold   <= THRESHOLD_RESET;
            cfg_reg.long_press_ticks  <= LONG_PRESS_RESET;
            cfg_reg.unlock_ticks      <= UNLOCK_RESET;
            cfg_reg.vibrate_gap_ticks <= VIB_GAP_RESET;
            cfg_reg.hide_ticks        <= HIDE_RESET;
        end
        else if (cfg_valid) begin
            case (cfg_index)
                REG_BAR_ENABLED:     cfg_reg.bar_enabled       <= cfg_data[0];
                REG_INITIAL_LEVEL:   cfg_reg.initial_level     <= cfg_data[LEVEL_W-1:0];
                REG_TOUCH_THRESHOLD: cfg_reg.touch_threshold   <= cfg_data;
                REG_LONG_PRESS:      cfg_reg.long_press_ticks  <= cfg_data[LONG_W-1:0];
                REG_UNLOCK_TICKS:    cfg_reg.unlock_ticks      <= cfg_data[UNLOCK_W-1:0];
                REG_VIBRATE_GAP:     cfg_reg.vibrate_gap_ticks <= cfg_data[VIB_W-1:0];
                REG_HIDE_TICKS:      cfg_reg.hide_ticks        <= cfg_data[HIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // a level write also reloads the live level
    assign level_load.load  = cfg_valid && (cfg_index == REG_INITIAL_LEVEL);
    assign level_load.value = clamp_level({1'b0, cfg_data[LEVEL_W-1:0]});
    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/tubs_level_map.sv -----
// maps a q1.14 slider position to a backlight level of 1 to 100
// depends on tubs_pkg
module tubs_level_map (
    input  logic [tubs_pkg::POS_W-1:0]   slider_position,
    output logic [tubs_pkg::LEVEL_W-1:0] mapped_level
);
    import tubs_pkg::*;

    logic signed [POS_W:0]   span;
    logic [MAP_PROD_W-1:0]   prod;

    // top of the slider is dim, bottom bright
    assign span = POS_TOP - $signed({slider_position[POS_W-1], slider_position});
    assign prod = MAP_PROD_W'(span[POS_W-1:0]) * LEVEL_SCALE;

    always_comb
    begin
        if (span <= 0) begin
            mapped_level = LEVEL_MIN;
        end
        else begin
            mapped_level = clamp_level(prod[MAP_PROD_W-1:15]);
        end
    end

endmodule

// ----- hw/rtl/tubs_step.sv -----
// per-tick state registers and next-state logic: unlock, adjust, haptics, hide
// depends on tubs_pkg and tubs_level_map
module tubs_step #(
    parameter int TICK_COUNT_BITS = tubs_pkg::TICK_COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  tubs_pkg::cfg_t        cfg,
    input  tubs_pkg::level_load_t level_load,
    input  tubs_pkg::in_item_t    item,
    output tubs_pkg::out_item_t   result
);
    import tubs_pkg::*;

    localparam int AGE_W = TICK_COUNT_BITS + 1;

    logic [HELD_W-1:0]  held_reg,   held_next;
    logic [AGE_W-1:0]   age_reg,    age_next;
    logic               unlock_reg, unlock_next;
    logic               adj_reg,    adj_next;
    logic [LEVEL_W-1:0] cur_reg,    cur_next;
    logic [LEVEL_W-1:0] last_reg,   last_next;
    logic [VIB_W-1:0]   vib_age_reg, vib_age_next;
    logic [HIDE_W-1:0]  hide_reg,   hide_next;
    logic               vis_reg,    vis_next;

    logic [LEVEL_W-1:0] mapped_level;
    logic               pressed;
    logic               applied;
    logic               vib;
    logic               persist;

    tubs_level_map u_level_map (
        .slider_position (item.slider_position),
        .mapped_level    (mapped_level)
    );

    assign pressed = (item.upper_middle_strength > cfg.touch_threshold) ||
                     (item.lower_middle_strength > cfg.touch_threshold);

    always_comb
    begin
        vib_age_next = (vib_age_reg != '1) ? vib_age_reg + 1'b1 : vib_age_reg;
        age_next     = (unlock_reg && (age_reg != '1)) ? age_reg + 1'b1 : age_reg;
        hide_next    = hide_reg;
        vis_next     = vis_reg;
        if (hide_reg != '0) begin
            hide_next = hide_reg - 1'b1;
            if (hide_next == '0) begin
                vis_next = 1'b0;
            end
        end
        held_next   = held_reg;
        unlock_next = unlock_reg;
        adj_next    = adj_reg;
        cur_next    = cur_reg;
        last_next   = last_reg;
        applied     = 1'b0;
        vib         = 1'b0;
        persist     = 1'b0;

        if (!cfg.bar_enabled || item.menu_active) begin
            unlock_next = 1'b0;
            adj_next    = 1'b0;
            held_next   = '0;
            hide_next   = '0;
            vis_next    = 1'b0;
        end
        else begin
            if (pressed) begin
                if (held_reg != '1) begin
                    held_next = held_reg + 1'b1;
                end
                if (held_next > HELD_W'(cfg.long_press_ticks)) begin
                    unlock_next = 1'b1;
                    age_next    = '0;
                end
            end
            else begin
                held_next = '0;
                if (unlock_reg && (AGE_CMP_W'(age_next) > AGE_CMP_W'(cfg.unlock_ticks))) begin
                    unlock_next = 1'b0;
                end
            end

            if (unlock_next && item.slider_touched) begin
                adj_next  = 1'b1;
                vis_next  = 1'b1;
                hide_next = '0;
                if (mapped_level != last_reg) begin
                    last_next = mapped_level;
                    if (vib_age_next >= cfg.vibrate_gap_ticks) begin
                        vib_age_next = '0;
                        vib          = 1'b1;
                    end
                end
                cur_next = mapped_level;
                applied  = 1'b1;
            end
            else if (adj_reg) begin
                adj_next  = 1'b0;
                persist   = 1'b1;
                hide_next = (cfg.hide_ticks != '0) ? cfg.hide_ticks : HIDE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            held_reg    <= '0;
            age_reg     <= '0;
            unlock_reg  <= 1'b0;
            adj_reg     <= 1'b0;
            vib_age_reg <= '1;
            hide_reg    <= '0;
            vis_reg     <= 1'b0;
        end
        else if (advance) begin
            held_reg    <= held_next;
            age_reg     <= age_next;
            unlock_reg  <= unlock_next;
            adj_reg     <= adj_next;
            vib_age_reg <= vib_age_next;
            hide_reg    <= hide_next;
            vis_reg     <= vis_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cur_reg  <= LEVEL_RESET;
            last_reg <= LEVEL_RESET;
        end
        else if (level_load.load) begin
            cur_reg  <= level_load.value;
            last_reg <= level_load.value;
        end
        else if (advance) begin
            cur_reg  <= cur_next;
            last_reg <= last_next;
        end
    end

    assign result.level              = cur_next;
    assign result.level_applied      = applied;
    assign result.vibrate            = vib;
    assign result.persist            = persist;
    assign result.bar_visible        = vis_next;
    assign result.suppress_detectors = unlock_next || adj_next;
    assign result.unlocked           = unlock_next;

endmodule

// ----- hw/rtl/touch_unlock_backlight_slider.sv -----
// top level of the touch unlock backlight slider: input register, step logic, result register
// a request waits in the input register, then its result is registered in the result register
// throughput: one request per cycle, limited only by out_ready
// reset: asynchronous active-low rst_n empties both registers and loads register defaults
// depends on tubs_pkg, tubs_cfg_regs, tubs_step
module touch_unlock_backlight_slider #(
    parameter int TICK_COUNT_BITS = tubs_pkg::TICK_COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tubs_pkg::STRENGTH_W-1:0]     upper_middle_strength,
    input  logic [tubs_pkg::STRENGTH_W-1:0]     lower_middle_strength,
    input  logic                                slider_touched,
    input  logic signed [tubs_pkg::POS_W-1:0]   slider_position,
    input  logic                                menu_active,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tubs_pkg::LEVEL_W-1:0]        level,
    output logic                                level_applied,
    output logic                                vibrate,
    output logic                                persist,
    output logic                                bar_visible,
    output logic                                suppress_detectors,
    output logic                                unlocked,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tubs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tubs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tubs_pkg::*;

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    out_item_t   result;
    cfg_t        cfg;
    level_load_t level_load;
    logic        advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    tubs_cfg_regs u_cfg_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .level_load (level_load)
    );

    tubs_step #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cfg        (cfg),
        .level_load (level_load),
        .item       (in_item_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (in_valid && in_ready) begin
                in_valid_reg <= 1'b1;
            end
            else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready) begin
            in_item_reg.upper_middle_strength <= upper_middle_strength;
            in_item_reg.lower_middle_strength <= lower_middle_strength;
            in_item_reg.slider_touched        <= slider_touched;
            in_item_reg.slider_position       <= slider_position;
            in_item_reg.menu_active           <= menu_active;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign out_valid          = out_valid_reg;
    assign level              = out_item_reg.level;
    assign level_applied      = out_item_reg.level_applied;
    assign vibrate            = out_item_reg.vibrate;
    assign persist            = out_item_reg.persist;
    assign bar_visible        = out_item_reg.bar_visible;
    assign suppress_detectors = out_item_reg.suppress_detectors;
    assign unlocked           = out_item_reg.unlocked;

endmodule

// ----- hw/rtl/tubs_checker.sv -----
// port-level checks for the touch unlock backlight slider, bound to the top level
// depends on tubs_pkg and touch_unlock_backlight_slider
module tubs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [tubs_pkg::LEVEL_W-1:0] level,
    input logic                         level_applied,
    input logic                         vibrate,
    input logic                         persist,
    input logic                         bar_visible,
    input logic                         suppress_detectors,
    input logic                         unlocked
);
    import tubs_pkg::*;

    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(level) && $stable(vibrate))
        else $error("result changed while stalled");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level >= LEVEL_MIN) && (level <= LEVEL_MAX))
        else $error("level out of range");

    a_applied_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && level_applied |-> unlocked && bar_visible && suppress_detectors)
        else $error("level applied while locked or hidden");

    a_vibrate_applied: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && vibrate |-> level_applied && !persist)
        else $error("haptic pulse without level change");

    a_persist_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && persist |-> !level_applied && bar_visible)
        else $error("persist while still adjusting");

endmodule

bind touch_unlock_backlight_slider tubs_checker u_tubs_checker (.*);

// ----- tb/sv/touch_unlock_backlight_slider_test.sv -----
// self-checking testbench for touch_unlock_backlight_slider: poll ticks with a per-tick model
// of unlock, slider level, haptic, persist and hide behavior, compared on every result
// depends on tubs_pkg and the touch_unlock_backlight_slider rtl
module touch_unlock_backlight_slider_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tubs_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int HOLD_CYCLES = 60;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int AGE_W = TICK_COUNT_BITS_DEF + 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
    localparam logic [HELD_W-1:0] HELD_SAT = '1;
    localparam logic [VIB_W-1:0] PULSE_SAT = '1;
    localparam logic [AGE_W-1:0] AGE_SAT = '1;

    typedef enum int {
        READY_STEADY,
        READY_SPARSE,
        READY_TOGGLE,
        READY_COIN
    } ready_style_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [STRENGTH_W-1:0] upper_middle_strength = '0;
    logic [STRENGTH_W-1:0] lower_middle_strength = '0;
    logic slider_touched = 1'b0;
    logic signed [POS_W-1:0] slider_position = '0;
    logic menu_active = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [LEVEL_W-1:0] level;
    logic level_applied;
    logic vibrate;
    logic persist;
    logic bar_visible;
    logic suppress_detectors;
    logic unlocked;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cfg_t settings;
    logic [HELD_W-1:0] press_run;
    logic [AGE_W-1:0] unlock_age;
    logic unlock_open;
    logic sliding;
    logic [LEVEL_W-1:0] level_now;
    logic [LEVEL_W-1:0] level_prev;
    logic [VIB_W-1:0] pulse_age;
    logic [HIDE_W-1:0] hide_left;
    logic bar_shown;

    out_item_t backlight_due[$];
    int mismatches = 0;
    int ticks_sent = 0;
    int burst_left = 0;
    bit sender_steady = 1'b0;
    bit hold_request = 1'b0;

    touch_unlock_backlight_slider DUT (.*);

    always #HALF_PERIOD clk = ~clk;

    function automatic logic [LEVEL_W-1:0] bounded_level(input int v);
        if (v < int'(LEVEL_MIN))
        begin
            return LEVEL_MIN;
        end
        if (v > int'(LEVEL_MAX))
        begin
            return LEVEL_MAX;
        end
        return v[LEVEL_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] slider_to_level(input logic [POS_W-1:0] pos);
        int span;
        span = 16384 - int'($signed(pos));
        if (span <= 0)
        begin
            return LEVEL_MIN;
        end
        return bounded_level((span * 100) >>> 15);
    endfunction

    function automatic void reset_model();
        settings.bar_enabled = 1'b1;
        settings.initial_level = LEVEL_RESET;
        settings.touch_threshold = THRESHOLD_RESET;
        settings.long_press_ticks = LONG_PRESS_RESET;
        settings.unlock_ticks = UNLOCK_RESET;
        settings.vibrate_gap_ticks = VIB_GAP_RESET;
        settings.hide_ticks = HIDE_RESET;
        press_run = '0;
        unlock_age = '0;
        unlock_open = 1'b0;
        sliding = 1'b0;
        level_now = LEVEL_RESET;
        level_prev = LEVEL_RESET;
        pulse_age = PULSE_SAT;
        hide_left = '0;
        bar_shown = 1'b0;
    endfunction

    function automatic out_item_t step_backlight(input in_item_t tick);
        out_item_t r;
        logic [LEVEL_W-1:0] lvl;
        r = '0;
        if (pulse_age != PULSE_SAT)
        begin
            pulse_age++;
        end
        if (unlock_open && unlock_age != AGE_SAT)
        begin
            unlock_age++;
        end
        if (hide_left != '0)
        begin
            hide_left--;
            if (hide_left == '0)
            begin
                bar_shown = 1'b0;
            end
        end
        if (!settings.bar_enabled || tick.menu_active)
        begin
            unlock_open = 1'b0;
            sliding = 1'b0;
            press_run = '0;
            hide_left = '0;
            bar_shown = 1'b0;
        end
        else
        begin
            if (tick.upper_middle_strength > settings.touch_threshold ||
                tick.lower_middle_strength > settings.touch_threshold)
            begin
                if (press_run != HELD_SAT)
                begin
                    press_run++;
                end
                if (press_run > settings.long_press_ticks)
                begin
                    unlock_open = 1'b1;
                    unlock_age = '0;
                end
            end
            else
            begin
                press_run = '0;
                if (unlock_open && unlock_age > settings.unlock_ticks)
                begin
                    unlock_open = 1'b0;
                end
            end
            if (unlock_open && tick.slider_touched)
            begin
                lvl = slider_to_level(tick.slider_position);
                sliding = 1'b1;
                bar_shown = 1'b1;
                hide_left = '0;
                if (lvl != level_prev)
                begin
                    level_prev = lvl;
                    if (pulse_age >= settings.vibrate_gap_ticks)
                    begin
                        pulse_age = '0;
                        r.vibrate = 1'b1;
                    end
                end
                level_now = lvl;
                r.level_applied = 1'b1;
            end
            else if (sliding)
            begin
                sliding = 1'b0;
                r.persist = 1'b1;
                hide_left = settings.hide_ticks;
                if (hide_left == '0)
                begin
                    hide_left = HIDE_W'(1);
                end
            end
        end
        r.level = level_now;
        r.bar_visible = bar_shown;
        r.suppress_detectors = unlock_open || sliding;
        r.unlocked = unlock_open;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (backlight_due.size() == 0)
            begin
                $error("result arrived with no request pending");
                mismatches++;
            end
            else
            begin
                want = backlight_due.pop_front();
                check_field("level", want.level, level);
                check_field("level_applied", want.level_applied, level_applied);
                check_field("vibrate", want.vibrate, vibrate);
                check_field("persist", want.persist, persist);
                check_field("bar_visible", want.bar_visible, bar_visible);
                check_field("suppress_detectors", want.suppress_detectors, suppress_detectors);
                check_field("unlocked", want.unlocked, unlocked);
            end
        end
    end

    initial
    begin : receiver
        int stretch_left;
        ready_style_t style;
        stretch_left = 0;
        style = READY_STEADY;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stretch_left = $urandom_range(4, 40);
                    style = ready_style_t'($urandom_range(0, 3));
                end
                stretch_left--;
                case (style)
                    READY_STEADY: out_ready <= 1'b1;
                    READY_SPARSE: out_ready <= ($urandom_range(0, 3) != 0);
                    READY_TOGGLE: out_ready <= ~out_ready;
                    default:      out_ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic poll(input logic [STRENGTH_W-1:0] up, input logic [STRENGTH_W-1:0] lo,
                        input logic touched, input logic [POS_W-1:0] pos, input logic menu);
        in_item_t tick;
        int gap;
        tick.upper_middle_strength = up;
        tick.lower_middle_strength = lo;
        tick.slider_touched = touched;
        tick.slider_position = pos;
        tick.menu_active = menu;
        if (!sender_steady)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 30);
                gap = $urandom_range(0, 5);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        in_valid <= 1'b1;
        upper_middle_strength <= up;
        lower_middle_strength <= lo;
        slider_touched <= touched;
        slider_position <= pos;
        menu_active <= menu;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ticks_sent++;
        backlight_due.push_back(step_backlight(tick));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (backlight_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value,
                             input int width);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        for (int b = 0; b < width; b++)
        begin
            data[b] = value[b];
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_BAR_ENABLED:     settings.bar_enabled = data[0];
            REG_INITIAL_LEVEL:
            begin
                settings.initial_level = data[LEVEL_W-1:0];
                level_now = bounded_level(int'(data[LEVEL_W-1:0]));
                level_prev = level_now;
            end
            REG_TOUCH_THRESHOLD: settings.touch_threshold = data;
            REG_LONG_PRESS:      settings.long_press_ticks = data[LONG_W-1:0];
            REG_UNLOCK_TICKS:    settings.unlock_ticks = data;
            REG_VIBRATE_GAP:     settings.vibrate_gap_ticks = data[VIB_W-1:0];
            REG_HIDE_TICKS:      settings.hide_ticks = data[HIDE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int en, input int lvl, input int thr, input int lp,
                             input int unl, input int gap, input int hide);
        settle();
        write_reg(REG_BAR_ENABLED, en, 1);
        write_reg(REG_INITIAL_LEVEL, lvl, LEVEL_W);
        write_reg(REG_TOUCH_THRESHOLD, thr, STRENGTH_W);
        write_reg(REG_LONG_PRESS, lp, LONG_W);
        write_reg(REG_UNLOCK_TICKS, unl, UNLOCK_W);
        write_reg(REG_VIBRATE_GAP, gap, VIB_W);
        write_reg(REG_HIDE_TICKS, hide, HIDE_W);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [STRENGTH_W-1:0] strong_pad();
        if (settings.touch_threshold == '1)
        begin
            return '1;
        end
        return STRENGTH_W'($urandom_range(int'(settings.touch_threshold) + 1, 65535));
    endfunction

    function automatic logic [STRENGTH_W-1:0] weak_pad();
        return STRENGTH_W'($urandom_range(0, int'(settings.touch_threshold)));
    endfunction

    function automatic logic [POS_W-1:0] any_position();
        logic [POS_W-1:0] p;
        if ($urandom_range(0, 4) == 0)
        begin
            p = POS_W'($urandom);
            return p;
        end
        p = POS_W'($urandom_range(0, 32768));
        return p - 16'd16384;
    endfunction

    // long (or deliberately short) press, a run of slider touches, release and rest
    task automatic slider_session(input bit short_press);
        int hold_len;
        int strokes;
        int rest;
        logic [POS_W-1:0] pos;
        if (short_press)
        begin
            hold_len = $urandom_range(0, settings.long_press_ticks);
        end
        else
        begin
            hold_len = settings.long_press_ticks + 1 + $urandom_range(0, 2);
        end
        repeat (hold_len)
        begin
            if ($urandom_range(0, 1))
            begin
                poll(strong_pad(), STRENGTH_W'($urandom), $urandom_range(0, 3) == 0,
                     any_position(), 1'b0);
            end
            else
            begin
                poll(STRENGTH_W'($urandom), strong_pad(), $urandom_range(0, 3) == 0,
                     any_position(), 1'b0);
            end
        end
        strokes = $urandom_range(1, 12);
        pos = any_position();
        repeat (strokes)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                pos = any_position();
            end
            poll(($urandom_range(0, 5) == 0) ? strong_pad() : weak_pad(), weak_pad(), 1'b1, pos,
                 $urandom_range(0, 29) == 0);
        end
        rest = $urandom_range(1, 10);
        repeat (rest)
        begin
            poll(weak_pad(), weak_pad(), $urandom_range(0, 5) == 0, any_position(), 1'b0);
        end
        if (settings.unlock_ticks < 40 && $urandom_range(0, 1))
        begin
            repeat (settings.unlock_ticks + 2)
            begin
                poll(weak_pad(), weak_pad(), 1'b0, any_position(), 1'b0);
            end
        end
    endtask

    task automatic run_sessions(input int count);
        int first;
        int pick;
        first = ticks_sent;
        while (ticks_sent - first < count)
        begin
            pick = $urandom_range(0, 9);
            if (settings.touch_threshold == '1 || settings.long_press_ticks > 60 || pick > 7)
            begin
                poll(STRENGTH_W'($urandom), STRENGTH_W'($urandom), 1'($urandom_range(0, 1)),
                     POS_W'($urandom), $urandom_range(0, 7) == 0);
            end
            else
            begin
                slider_session(pick == 7);
            end
        end
    endtask

    task automatic test_reset_state();
        poll(16'd0, 16'd0, 1'b0, 16'h0000, 1'b0);
        poll(16'd101, 16'd0, 1'b1, 16'h0000, 1'b0);
        poll(16'd0, 16'd101, 1'b1, 16'hC000, 1'b0);
        poll(16'd0, 16'd0, 1'b1, 16'h4000, 1'b0);
    endtask

    task automatic test_slider_extremes();
        configure(1, 0, 100, 0, 3, 0, 2);
        poll(16'd101, 16'd0, 1'b1, 16'h4000, 1'b0);
        poll(16'hFFFF, 16'd0, 1'b1, 16'h8000, 1'b0);
        poll(16'd0, 16'd101, 1'b1, 16'h7FFF, 1'b0);
        poll(16'd0, 16'd0, 1'b1, 16'h0000, 1'b0);
        poll(16'd0, 16'd0, 1'b1, 16'hC000, 1'b0);
        poll(16'd0, 16'd0, 1'b1, 16'h3FFF, 1'b0);
        poll(16'd0, 16'd0, 1'b0, 16'h0000, 1'b0);
        poll(16'd0, 16'd0, 1'b0, 16'h0000, 1'b0);
        poll(16'd0, 16'd0, 1'b0, 16'h0000, 1'b0);
        poll(16'd100, 16'd100, 1'b1, 16'h0000, 1'b0);
        poll(16'd101, 16'd0, 1'b1, 16'h0000, 1'b1);
        poll(16'd0, 16'd101, 1'b1, 16'h2000, 1'b0);
        poll(16'd0, 16'd101, 1'b1, 16'h2000, 1'b1);
    endtask

    task automatic test_disable_and_spare();
        settle();
        write_reg(REG_SPARE, $urandom, CFG_DATA_W);
        configure(0, 127, 100, 0, 3, 0, 2);
        poll(16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, 1'b0);
        poll(16'hFFFF, 16'd0, 1'b1, 16'h8000, 1'b0);
        poll(16'd0, 16'd0, 1'b0, 16'h0000, 1'b0);
        configure(1, 101, 100, 0, 3, 0, 2);
        poll(16'd200, 16'd0, 1'b1, 16'h0000, 1'b0);
        poll(16'd0, 16'd0, 1'b0, 16'h0000, 1'b0);
    endtask

    task automatic test_output_backpressure();
        configure(1, 50, 200, 2, 20, 3, 4);
        hold_request = 1'b1;
        sender_steady = 1'b1;
        run_sessions(40);
        sender_steady = 1'b0;
    endtask

    task automatic test_random_settings();
        configure(1, 80, 100, 50, 500, 10, 100);
        run_sessions(70);
        configure(1, 1, 0, 0, 0, 0, 0);
        run_sessions(60);
        configure(1, 100, 65535, 1023, 65535, 255, 1023);
        run_sessions(25);
        configure(1, 127, $urandom_range(0, 300), 1, 65535, 255, 1023);
        run_sessions(40);
        repeat (3)
        begin
            configure($urandom_range(0, 5) != 0, $urandom_range(0, 127),
                      $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 65534),
                      $urandom_range(0, 6), $urandom_range(0, 40), $urandom_range(0, 8),
                      $urandom_range(0, 8));
            run_sessions(60);
        end
    endtask

    initial
    begin
        reset_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_slider_extremes();
        test_disable_and_spare();
        test_output_backpressure();
        test_random_settings();
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/tubs_pkg.sv
hw/rtl/tubs_cfg_regs.sv
hw/rtl/tubs_level_map.sv
hw/rtl/tubs_step.sv
hw/rtl/touch_unlock_backlight_slider.sv
hw/rtl/tubs_checker.sv
tb/sv/touch_unlock_backlight_slider_test.sv
